// ===== hw/rtl/ssco_pkg.sv =====
// ----------------------------------------------------------------------------
// ssco_pkg
// Shared types and constants for the streaming substring search unit.
// ----------------------------------------------------------------------------
package ssco_pkg;

   // Longest pattern and width of the text position.
   localparam int MAX_PATTERN   = 8;
   localparam int INDEX_BITS    = 16;
   localparam int WINDOW_DEPTH  = MAX_PATTERN - 1;
   localparam int LEN_BITS      = 4;
   localparam int PAT_IDX_BITS  = 3;
   localparam int PATTERN_BITS  = 64;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};

   // Character constants for case folding.
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_DELTA   = 8'h20;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_PATTERN_LENGTH = 2'd1,
      CSR_CASE_SENSITIVE = 2'd2,
      CSR_START_OFFSET   = 2'd3
   } csr_index_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern_bytes;
      logic [LEN_BITS-1:0]     pattern_length;
      logic                    case_sensitive;
      logic [INDEX_BITS-1:0]   start_offset;
   } cfg_type;

   // Request and response payloads.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] match_index;
   } rsp_type;

   // Fold a to z to upper case when folding is enabled.
   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/substring_search_case_optional_unit.sv =====
// ----------------------------------------------------------------------------
// substring_search_case_optional_unit
// Streaming search for a configured pattern of up to eight bytes.
// ----------------------------------------------------------------------------
// Text bytes arrive on the req_ channel, one request per byte, with last set
// on the final byte of a text. Each byte is compared against the pattern,
// optionally with a to z folded to upper case. For each request flagged last
// one response leaves on the rsp_ channel: found and the start index of the
// earliest match at or after start_offset (zero when not found).
// A request is taken into an input register and processed by the window
// compare when it leaves that register. For a last byte the result is then
// written into the response register, which drives rsp_valid and rsp_data.
// One request is accepted every cycle while req_stall is low; the input
// register advances while the response register holds a stalled response,
// and req_stall rises only when a last byte waits behind a stalled response.
// A stalled response holds its value. Reset empties both registers, clears
// the text state and sets the registers to their defaults (exact compare,
// empty pattern). The csr_ port writes a register per cycle; the user must
// use it only while no text is in flight, and the block does not enforce it.
// ----------------------------------------------------------------------------
module substring_search_case_optional_unit
   import ssco_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type step_rsp;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   logic    req_take;
   logic    step_go;

   ssco_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssco_match u_match (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_go),
      .step_data  (in_data_ff),
      .cfg        (cfg),
      .step_rsp   (step_rsp)
   );

   // Advance the input register unless a last byte meets a stalled response.
   assign step_go   = in_valid_ff && (!in_data_ff.last || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_go) begin
         in_valid_in = 1'b0;
      end
   end

   // Load a response on a last byte, drop it once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_go && in_data_ff.last) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_go && in_data_ff.last) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hw/rtl/ssco_csr.sv =====
// ----------------------------------------------------------------------------
// ssco_csr
// Configuration registers of the substring search unit, written by index.
// ----------------------------------------------------------------------------
module ssco_csr
   import ssco_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  cfg_in.pattern_bytes  = csr_wdata[PATTERN_BITS-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_wdata[LEN_BITS-1:0];
            CSR_CASE_SENSITIVE: cfg_in.case_sensitive = csr_wdata[0];
            CSR_START_OFFSET:   cfg_in.start_offset   = csr_wdata[INDEX_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers; exact compare after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes  <= '0;
         cfg_ff.pattern_length <= '0;
         cfg_ff.case_sensitive <= 1'b1;
         cfg_ff.start_offset   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/ssco_match.sv =====
// ----------------------------------------------------------------------------
// ssco_match
// Window compare and per-text match state: one text byte per step.
// ----------------------------------------------------------------------------
module ssco_match
   import ssco_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_valid,
   input  req_type step_data,
   input  cfg_type cfg,
   output rsp_type step_rsp
);

   logic [7:0]            recent_ff [WINDOW_DEPTH];
   logic [7:0]            recent_in [WINDOW_DEPTH];
   logic [INDEX_BITS-1:0] pos_ff;
   logic [INDEX_BITS-1:0] pos_in;
   logic                  seen_ff;
   logic                  seen_in;
   logic [INDEX_BITS-1:0] first_ff;
   logic [INDEX_BITS-1:0] first_in;

   logic [7:0]            pat     [MAX_PATTERN];
   logic [7:0]            win     [MAX_PATTERN];
   logic [LEN_BITS-1:0]   clip_len;
   logic [LEN_BITS-1:0]   eff_len;
   logic [LEN_BITS-1:0]   idx;
   logic                  fold_en;
   logic                  all_eq;
   logic [INDEX_BITS:0]   pos_p1;
   logic [INDEX_BITS:0]   start;
   logic                  hit;
   logic                  seen_next;
   logic [INDEX_BITS-1:0] first_next;

   // Split the pattern and build the window, newest byte first.
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat[j] = cfg.pattern_bytes[j*8 +: 8];
      end
      win[0] = step_data.text_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   // Clip the length, then cut it at the first zero pattern byte.
   always_comb begin
      clip_len = (cfg.pattern_length > LEN_BITS'(MAX_PATTERN)) ?
                 LEN_BITS'(MAX_PATTERN) : cfg.pattern_length;
      eff_len  = clip_len;
      for (int j = MAX_PATTERN - 1; j >= 0; j--) begin
         if ((LEN_BITS'(j) < clip_len) && (pat[j] == 8'h00)) begin
            eff_len = LEN_BITS'(j);
         end
      end
   end

   // Compare the last eff_len bytes with the pattern.
   always_comb begin
      fold_en = ~cfg.case_sensitive;
      all_eq  = 1'b1;
      idx     = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (LEN_BITS'(j) < eff_len) begin
            idx = eff_len - LEN_BITS'(j) - LEN_BITS'(1);
            if (fold_char(win[idx[PAT_IDX_BITS-1:0]], fold_en) != fold_char(pat[j], fold_en)) begin
               all_eq = 1'b0;
            end
         end
      end
   end

   // Qualify the match by position and start offset.
   always_comb begin
      pos_p1     = {1'b0, pos_ff} + (INDEX_BITS+1)'(1);
      start      = pos_p1 - (INDEX_BITS+1)'(eff_len);
      hit        = !seen_ff && (eff_len != '0) && (pos_ff != POS_MAX) &&
                   (pos_p1 >= (INDEX_BITS+1)'(eff_len)) &&
                   (start >= {1'b0, cfg.start_offset}) && all_eq;
      seen_next  = seen_ff | hit;
      first_next = hit ? start[INDEX_BITS-1:0] : first_ff;
      step_rsp.found       = seen_next;
      step_rsp.match_index = seen_next ? first_next : '0;
   end

   // Advance the window and position, clear everything after the last byte.
   always_comb begin
      recent_in = recent_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      if (step_valid) begin
         if (step_data.last) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
               recent_in[k] = '0;
            end
            pos_in   = '0;
            seen_in  = 1'b0;
            first_in = '0;
         end else begin
            recent_in[0] = step_data.text_byte;
            for (int k = 1; k < WINDOW_DEPTH; k++) begin
               recent_in[k] = recent_ff[k-1];
            end
            pos_in   = (pos_ff != POS_MAX) ? pos_p1[INDEX_BITS-1:0] : pos_ff;
            seen_in  = seen_next;
            first_in = first_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            recent_ff[k] <= '0;
         end
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
      end else begin
         recent_ff <= recent_in;
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
      end
   end

endmodule
